### design/lru_key_value_cache_unit_defines.svh
// assertion macros for the lru key-value cache checker
// expects clk and arst_n to be visible where a macro is used
`ifndef LRU_KEY_VALUE_CACHE_UNIT_DEFINES_SVH
`define LRU_KEY_VALUE_CACHE_UNIT_DEFINES_SVH

// same-cycle implication, disabled during reset
`define LKV_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled during reset
`define LKV_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### design/lkv_pkg.sv
// shared types and constants for the lru key-value cache
// used by the interfaces, the cell row, the controller and the top level
`timescale 1ns / 1ps

package lkv_pkg;

	localparam logic KIND_GET = 1'b0;
	localparam logic KIND_SET = 1'b1;

	localparam int DATA_W = 32;
	localparam int CAP_W  = 5;
	localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;
	localparam logic [DATA_W-1:0] MISS_VALUE = '1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_LOOKUP,
		ST_UPDATE
	} lkv_state_t;

	typedef enum logic [1:0] {
		CELL_NONE,
		CELL_LOOKUP,
		CELL_TOUCH,
		CELL_INSERT
	} cell_op_t;

	typedef struct packed {
		cell_op_t                 op;
		logic                     write_value;
		logic                     evict;
		logic signed [DATA_W-1:0] key;
		logic signed [DATA_W-1:0] value;
	} cell_ctl_t;

endpackage

### design/lkv_ifs.sv
// request, response and capacity-write channels of the lru key-value cache
// depends on lkv_pkg for field widths
`timescale 1ns / 1ps

interface lkv_req_if;
	logic                              valid;
	logic                              ready;
	logic                              kind;
	logic signed [lkv_pkg::DATA_W-1:0] key;
	logic signed [lkv_pkg::DATA_W-1:0] value;

	modport source (output valid, output kind, output key, output value, input ready);
	modport sink (input valid, input kind, input key, input value, output ready);
endinterface

interface lkv_rsp_if;
	logic                              valid;
	logic                              ready;
	logic                              found;
	logic signed [lkv_pkg::DATA_W-1:0] read_value;

	modport source (output valid, output found, output read_value, input ready);
	modport sink (input valid, input found, input read_value, output ready);
endinterface

interface lkv_cfg_if;
	logic                       valid;
	logic                       ready;
	logic [lkv_pkg::CAP_W-1:0]  capacity;

	modport source (output valid, output capacity, input ready);
	modport sink (input valid, input capacity, output ready);
endinterface

### design/lru_key_value_cache_unit.sv
// top level of the lru key-value cache: a row of slot cells and its sequencer
// depends on lkv_pkg, the channel interfaces, lkv_cell and lkv_ctrl
`timescale 1ns / 1ps
// usage
// req carries get (kind 0) or set (kind 1) requests with key and value.
// rsp returns found and read_value for every get; a set gives no response.
// a miss returns found 0 and read_value all ones.
// cfg writes the capacity register (reset 16); write it only while idle.
// capacity 0 acts as 1, capacity above ENTRIES acts as ENTRIES.
// each request passes a lookup step, in which the key is compared in every
// cell and hit data ripples along the row, and then an update step, in which
// on a hit or a set all cells age, evict or insert at once. a new request is
// taken in the update step, before the previous one is through.
// a get response is registered at the end of its update step and is held
// in an output register until taken. a stalled response only holds the next
// get in its lookup step; sets go on.
// reset clears all valid bits, the live count and the response valid flag;
// no clearing pass is needed.

module lru_key_value_cache_unit #(
	parameter int ENTRIES = 16
) (
	input  logic      clk,
	input  logic      arst_n,
	lkv_req_if.sink   req,
	lkv_rsp_if.source rsp,
	lkv_cfg_if.sink   cfg
);

	localparam int RW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int CW = $clog2(ENTRIES + 1);

	lkv_pkg::cell_ctl_t         cell_ctl;
	logic [RW-1:0]              touch_rank;
	logic [RW-1:0]              evict_rank;
	logic                       free_c      [ENTRIES+1];
	logic                       hit_c       [ENTRIES+1];
	logic [RW-1:0]              hit_rank_c  [ENTRIES+1];
	logic [lkv_pkg::DATA_W-1:0] hit_value_c [ENTRIES+1];

	assign free_c[0]      = 1'b0;
	assign hit_c[0]       = 1'b0;
	assign hit_rank_c[0]  = '0;
	assign hit_value_c[0] = '0;

	for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
		lkv_cell #(
			.RW(RW)
		) u_cell (
			.clk          (clk),
			.arst_n       (arst_n),
			.ctl          (cell_ctl),
			.touch_rank   (touch_rank),
			.evict_rank   (evict_rank),
			.free_in      (free_c[i]),
			.hit_in       (hit_c[i]),
			.hit_rank_in  (hit_rank_c[i]),
			.hit_value_in (hit_value_c[i]),
			.free_out     (free_c[i+1]),
			.hit_out      (hit_c[i+1]),
			.hit_rank_out (hit_rank_c[i+1]),
			.hit_value_out(hit_value_c[i+1])
		);
	end

	lkv_ctrl #(
		.ENTRIES(ENTRIES),
		.RW     (RW),
		.CW     (CW)
	) u_ctrl (
		.clk            (clk),
		.arst_n         (arst_n),
		.req            (req),
		.rsp            (rsp),
		.cfg            (cfg),
		.chain_hit      (hit_c[ENTRIES]),
		.chain_hit_rank (hit_rank_c[ENTRIES]),
		.chain_hit_value(hit_value_c[ENTRIES]),
		.cell_ctl       (cell_ctl),
		.touch_rank     (touch_rank),
		.evict_rank     (evict_rank)
	);

endmodule

### design/lkv_cell.sv
// one slot of the cache row: key, value, valid bit and recency rank
// depends on lkv_pkg; chains hit data and the free-slot search to its neighbor
`timescale 1ns / 1ps

module lkv_cell #(
	parameter int RW = 4
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  lkv_pkg::cell_ctl_t                ctl,
	input  logic [RW-1:0]                     touch_rank,
	input  logic [RW-1:0]                     evict_rank,
	input  logic                              free_in,
	input  logic                              hit_in,
	input  logic [RW-1:0]                     hit_rank_in,
	input  logic [lkv_pkg::DATA_W-1:0]        hit_value_in,
	output logic                              free_out,
	output logic                              hit_out,
	output logic [RW-1:0]                     hit_rank_out,
	output logic [lkv_pkg::DATA_W-1:0]        hit_value_out
);

	logic                       valid_q;
	logic                       hit_q;
	logic [lkv_pkg::DATA_W-1:0] key_q;
	logic [lkv_pkg::DATA_W-1:0] value_q;
	logic [RW-1:0]              rank_q;
	logic                       match;
	logic                       evicting;
	logic                       free_here;
	logic                       claim;

	always_comb begin
		match         = valid_q && (key_q == ctl.key);
		hit_out       = hit_in | match;
		hit_rank_out  = hit_rank_in | (match ? rank_q : '0);
		hit_value_out = hit_value_in | (match ? value_q : '0);
		evicting      = (ctl.op == lkv_pkg::CELL_INSERT) && ctl.evict && valid_q
			&& (rank_q >= evict_rank);
		free_here     = !valid_q || evicting;
		free_out      = free_in | free_here;
		claim         = (ctl.op == lkv_pkg::CELL_INSERT) && free_here && !free_in;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			hit_q   <= 1'b0;
		end else begin
			unique case (ctl.op)
				lkv_pkg::CELL_LOOKUP: begin
					hit_q <= match;
				end
				lkv_pkg::CELL_INSERT: begin
					if (claim) begin
						valid_q <= 1'b1;
					end else if (evicting) begin
						valid_q <= 1'b0;
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (ctl.op)
			lkv_pkg::CELL_TOUCH: begin
				if (hit_q) begin
					rank_q <= '0;
					if (ctl.write_value) begin
						value_q <= ctl.value;
					end
				end else if (valid_q && (rank_q < touch_rank)) begin
					rank_q <= rank_q + RW'(1);
				end
			end
			lkv_pkg::CELL_INSERT: begin
				if (claim) begin
					key_q   <= ctl.key;
					value_q <= ctl.value;
					rank_q  <= '0;
				end else if (valid_q && !evicting) begin
					rank_q <= rank_q + RW'(1);
				end
			end
			default: begin
			end
		endcase
	end

endmodule

### design/lkv_ctrl.sv
// sequencer of the lru key-value cache: request intake, lookup and update
// steps, capacity register, live count and the response register
// depends on lkv_pkg and the channel interfaces
`timescale 1ns / 1ps

module lkv_ctrl #(
	parameter int ENTRIES = 16,
	parameter int RW      = 4,
	parameter int CW      = 5
) (
	input  logic                       clk,
	input  logic                       arst_n,
	lkv_req_if.sink                    req,
	lkv_rsp_if.source                  rsp,
	lkv_cfg_if.sink                    cfg,
	input  logic                       chain_hit,
	input  logic [RW-1:0]              chain_hit_rank,
	input  logic [lkv_pkg::DATA_W-1:0] chain_hit_value,
	output lkv_pkg::cell_ctl_t         cell_ctl,
	output logic [RW-1:0]              touch_rank,
	output logic [RW-1:0]              evict_rank
);

	localparam int XW = (CW > lkv_pkg::CAP_W) ? CW : lkv_pkg::CAP_W;

	lkv_pkg::lkv_state_t        state_q;
	lkv_pkg::lkv_state_t        state_d;
	logic                       req_kind_q;
	logic [lkv_pkg::DATA_W-1:0] req_key_q;
	logic [lkv_pkg::DATA_W-1:0] req_value_q;
	logic                       hit_any_q;
	logic [RW-1:0]              hit_rank_q;
	logic [lkv_pkg::DATA_W-1:0] hit_value_q;
	logic [CW-1:0]              live_q;
	logic [lkv_pkg::CAP_W-1:0]  capacity_q;
	logic                       out_valid_q;
	logic                       out_found_q;
	logic [lkv_pkg::DATA_W-1:0] out_value_q;
	logic [XW-1:0]              cap_x;
	logic [CW-1:0]              cap_eff;
	logic                       req_fire;
	logic                       lookup_go;
	logic                       need_evict;
	logic                       do_insert;

	assign cfg.ready      = 1'b1;
	assign rsp.valid      = out_valid_q;
	assign rsp.found      = out_found_q;
	assign rsp.read_value = out_value_q;
	assign req.ready      = (state_q != lkv_pkg::ST_LOOKUP);
	assign req_fire       = req.valid && req.ready;

	// capacity zero acts as one, above the row size acts as the row size
	always_comb begin
		cap_x = XW'(capacity_q);
		if (capacity_q == '0) begin
			cap_eff = CW'(1);
		end else if (cap_x > XW'(ENTRIES)) begin
			cap_eff = CW'(ENTRIES);
		end else begin
			cap_eff = CW'(cap_x);
		end
	end

	assign need_evict = (live_q >= cap_eff);
	assign evict_rank = RW'(cap_eff - CW'(1));
	assign touch_rank = hit_rank_q;
	assign lookup_go  = (req_kind_q == lkv_pkg::KIND_SET) || !out_valid_q || rsp.ready;
	assign do_insert  = (state_q == lkv_pkg::ST_UPDATE) && !hit_any_q
		&& (req_kind_q == lkv_pkg::KIND_SET);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lkv_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d              = state_q;
		cell_ctl.op          = lkv_pkg::CELL_NONE;
		cell_ctl.write_value = (req_kind_q == lkv_pkg::KIND_SET);
		cell_ctl.evict       = need_evict;
		cell_ctl.key         = req_key_q;
		cell_ctl.value       = req_value_q;
		unique case (state_q)
			lkv_pkg::ST_IDLE: begin
				if (req_fire) begin
					state_d = lkv_pkg::ST_LOOKUP;
				end
			end
			lkv_pkg::ST_LOOKUP: begin
				cell_ctl.op = lkv_pkg::CELL_LOOKUP;
				if (lookup_go) begin
					state_d = lkv_pkg::ST_UPDATE;
				end
			end
			lkv_pkg::ST_UPDATE: begin
				if (hit_any_q) begin
					cell_ctl.op = lkv_pkg::CELL_TOUCH;
				end else if (req_kind_q == lkv_pkg::KIND_SET) begin
					cell_ctl.op = lkv_pkg::CELL_INSERT;
				end
				state_d = req_fire ? lkv_pkg::ST_LOOKUP : lkv_pkg::ST_IDLE;
			end
			default: begin
				state_d = lkv_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q  <= lkv_pkg::CAP_RESET;
			live_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				capacity_q <= cfg.capacity;
			end
			if (do_insert) begin
				live_q <= need_evict ? cap_eff : live_q + CW'(1);
			end
			if (rsp.valid && rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			if ((state_q == lkv_pkg::ST_UPDATE) && (req_kind_q == lkv_pkg::KIND_GET)) begin
				out_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req_fire) begin
			req_kind_q  <= req.kind;
			req_key_q   <= req.key;
			req_value_q <= req.value;
		end
		if (state_q == lkv_pkg::ST_LOOKUP) begin
			hit_any_q   <= chain_hit;
			hit_rank_q  <= chain_hit_rank;
			hit_value_q <= chain_hit_value;
		end
		if ((state_q == lkv_pkg::ST_UPDATE) && (req_kind_q == lkv_pkg::KIND_GET)) begin
			out_found_q <= hit_any_q;
			out_value_q <= hit_any_q ? hit_value_q : lkv_pkg::MISS_VALUE;
		end
	end

endmodule

### design/lkv_checker.sv
// port-level checks for the lru key-value cache, bound to the top level
// depends on lkv_pkg and the assertion macro header
`timescale 1ns / 1ps
`include "lru_key_value_cache_unit_defines.svh"

module lkv_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       req_valid,
	input logic                       req_ready,
	input logic                       req_kind,
	input logic                       rsp_valid,
	input logic                       rsp_ready,
	input logic                       rsp_found,
	input logic [lkv_pkg::DATA_W-1:0] rsp_read_value
);

	// a held response keeps its payload
	`LKV_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready,
		rsp_valid && $stable(rsp_found) && $stable(rsp_read_value),
		"lkv: stalled response changed")

	// a request always spends its next cycle in lookup
	`LKV_ASSERT_NEXT(a_req_lookup, req_valid && req_ready, !req_ready,
		"lkv: request taken during lookup")

	// a miss answers all ones
	`LKV_ASSERT_NOW(a_miss_value, rsp_valid && !rsp_found,
		rsp_read_value == lkv_pkg::MISS_VALUE, "lkv: miss value wrong")

	// a get with a free response register answers after its lookup and update steps
	`LKV_ASSERT_NEXT(a_get_latency,
		(req_valid && req_ready && (req_kind == lkv_pkg::KIND_GET)) ##1 !rsp_valid ##1 1'b1,
		rsp_valid, "lkv: get response late")

endmodule

bind lru_key_value_cache_unit lkv_checker u_lkv_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.req_valid     (req.valid),
	.req_ready     (req.ready),
	.req_kind      (req.kind),
	.rsp_valid     (rsp.valid),
	.rsp_ready     (rsp.ready),
	.rsp_found     (rsp.found),
	.rsp_read_value(rsp.read_value)
);

### test/tb_lru_key_value_cache_unit.sv
// testbench for lru_key_value_cache_unit: directed and random get/set traffic
// checked against a shadow lru store, with random idling on both channels
// depends on lkv_pkg, the lkv channel interfaces and the cache top level
`timescale 1ns / 1ps

module tb_lru_key_value_cache_unit;
	import lkv_pkg::*;

	localparam int SLOTS = 16;
	localparam int CYCLE_LIMIT = 400000;
	localparam int SETTLE_CYCLES = 8;
	localparam int RESET_CYCLES = 9;
	localparam logic [DATA_W-1:0] KEY_MIN = 32'h8000_0000;
	localparam logic [DATA_W-1:0] KEY_MAX = 32'h7fff_ffff;

	typedef struct packed {
		logic                     found;
		logic signed [DATA_W-1:0] read_value;
	} answer_t;

	typedef enum int {
		STALL_NONE,
		STALL_HALF,
		STALL_MOSTLY,
		STALL_PERIODIC
	} stall_mode_t;

	logic clk;
	logic arst_n;

	lkv_req_if req_ch();
	lkv_rsp_if rsp_ch();
	lkv_cfg_if cfg_ch();

	lru_key_value_cache_unit #(
		.ENTRIES(SLOTS)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch),
		.rsp(rsp_ch),
		.cfg(cfg_ch)
	);

	// shadow store
	logic [DATA_W-1:0] shadow_key[SLOTS];
	logic [DATA_W-1:0] shadow_value[SLOTS];
	bit                shadow_valid[SLOTS];
	int unsigned       shadow_rank[SLOTS];
	int unsigned       shadow_live;
	logic [CAP_W-1:0]  shadow_capacity;
	answer_t           expected_answers[$];

	int error_count = 0;
	int get_count = 0;
	int set_count = 0;
	int hit_count = 0;
	int miss_count = 0;
	int cap_writes = 0;
	int cycle_count = 0;
	int burst_left = 1;
	bit sender_gapless = 1'b0;
	int hold_seq = 0;
	int hold_len = 0;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("%0t: timeout after %0d cycles", $time, cycle_count);
			$display("** lru_key_value_cache_unit: FAILED **");
			$finish;
		end
	end

	function automatic void promote_slot(int s);
		int unsigned r;
		r = shadow_rank[s];
		for (int i = 0; i < SLOTS; i++)
			if (shadow_valid[i] && shadow_rank[i] < r)
				shadow_rank[i]++;
		shadow_rank[s] = 0;
	endfunction

	function automatic void apply_to_shadow_cache(logic kind, logic [DATA_W-1:0] key,
			logic [DATA_W-1:0] value);
		int hit_slot;
		int free_slot;
		int unsigned cap;
		bit evicted;
		hit_slot = -1;
		for (int i = 0; i < SLOTS; i++)
			if (shadow_valid[i] && shadow_key[i] == key) begin
				hit_slot = i;
				break;
			end
		if (kind == KIND_GET) begin
			if (hit_slot >= 0) begin
				promote_slot(hit_slot);
				expected_answers.push_back('{found: 1'b1, read_value: shadow_value[hit_slot]});
			end else begin
				expected_answers.push_back('{found: 1'b0, read_value: MISS_VALUE});
			end
			return;
		end
		if (hit_slot >= 0) begin
			promote_slot(hit_slot);
			shadow_value[hit_slot] = value;
			return;
		end
		cap = (shadow_capacity == 0) ? 1 : (shadow_capacity > SLOTS) ? SLOTS : shadow_capacity;
		// a lowered capacity drains several oldest slots at once
		evicted = 1'b1;
		while (shadow_live >= cap && shadow_live > 0 && evicted) begin
			evicted = 1'b0;
			for (int i = 0; i < SLOTS; i++)
				if (shadow_valid[i] && shadow_rank[i] == shadow_live - 1) begin
					shadow_valid[i] = 1'b0;
					shadow_live--;
					evicted = 1'b1;
					break;
				end
		end
		free_slot = -1;
		for (int i = 0; i < SLOTS; i++)
			if (!shadow_valid[i]) begin
				free_slot = i;
				break;
			end
		if (free_slot < 0)
			return;
		for (int i = 0; i < SLOTS; i++)
			if (shadow_valid[i])
				shadow_rank[i]++;
		shadow_key[free_slot] = key;
		shadow_value[free_slot] = value;
		shadow_valid[free_slot] = 1'b1;
		shadow_rank[free_slot] = 0;
		shadow_live++;
	endfunction

	task automatic send_request(logic kind, logic [DATA_W-1:0] key, logic [DATA_W-1:0] value);
		int gap;
		req_ch.valid <= 1'b1;
		req_ch.kind <= kind;
		req_ch.key <= key;
		req_ch.value <= value;
		do @(posedge clk); while (!req_ch.ready);
		apply_to_shadow_cache(kind, key, value);
		if (kind == KIND_GET)
			get_count++;
		else
			set_count++;
		burst_left--;
		if (burst_left <= 0) begin
			burst_left = $urandom_range(1, 12);
			gap = sender_gapless ? 0 : $urandom_range(1, 7);
			if (gap > 0) begin
				req_ch.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	task automatic settle();
		req_ch.valid <= 1'b0;
		while (expected_answers.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_capacity(logic [CAP_W-1:0] cap);
		settle();
		cfg_ch.valid <= 1'b1;
		cfg_ch.capacity <= cap;
		do @(posedge clk); while (!cfg_ch.ready);
		cfg_ch.valid <= 1'b0;
		shadow_capacity = cap;
		cap_writes++;
	endtask

	// receiver stall pattern, plus long hold-offs on demand
	initial begin
		stall_mode_t mode;
		int mode_left;
		int hold_left;
		int hold_seen;
		rsp_ch.ready <= 1'b0;
		mode = STALL_NONE;
		mode_left = 0;
		hold_left = 0;
		hold_seen = 0;
		forever begin
			@(posedge clk);
			if (hold_seq != hold_seen) begin
				hold_seen = hold_seq;
				hold_left = hold_len;
			end
			if (mode_left == 0) begin
				mode = stall_mode_t'($urandom_range(0, 3));
				mode_left = $urandom_range(20, 120);
			end
			mode_left--;
			if (hold_left > 0) begin
				hold_left--;
				rsp_ch.ready <= 1'b0;
			end else begin
				case (mode)
					STALL_NONE: rsp_ch.ready <= 1'b1;
					STALL_HALF: rsp_ch.ready <= 1'($urandom_range(0, 1));
					STALL_MOSTLY: rsp_ch.ready <= ($urandom_range(0, 3) == 0);
					default: rsp_ch.ready <= (mode_left % 3 == 0);
				endcase
			end
		end
	end

	always @(posedge clk) begin : check_answers
		answer_t want;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (expected_answers.size() == 0) begin
				error_count++;
				$display("%0t: response with no get waiting: expected none, actual found=%0b read_value=%0d",
					$time, rsp_ch.found, rsp_ch.read_value);
			end else begin
				want = expected_answers.pop_front();
				if (want.found)
					hit_count++;
				else
					miss_count++;
				if (rsp_ch.found !== want.found) begin
					error_count++;
					$display("%0t: found mismatch: expected %0b, actual %0b",
						$time, want.found, rsp_ch.found);
				end
				if (rsp_ch.read_value !== want.read_value) begin
					error_count++;
					$display("%0t: read_value mismatch: expected %0d, actual %0d",
						$time, want.read_value, rsp_ch.read_value);
				end
			end
		end
	end

	task automatic test_basic_lookups();
		send_request(KIND_GET, 32'd0, $urandom);
		send_request(KIND_SET, KEY_MIN, KEY_MAX);
		send_request(KIND_SET, KEY_MAX, KEY_MIN);
		send_request(KIND_SET, 32'd0, '1);
		send_request(KIND_GET, KEY_MIN, $urandom);
		send_request(KIND_GET, KEY_MAX, $urandom);
		send_request(KIND_GET, 32'd0, $urandom);
		send_request(KIND_GET, '1, $urandom);
		send_request(KIND_SET, KEY_MIN, 32'd0);
		send_request(KIND_GET, KEY_MIN, $urandom);
	endtask

	// store holds three keys when capacity drops to two
	task automatic test_eviction_order();
		write_capacity(CAP_W'(2));
		send_request(KIND_SET, 32'h0000_1234, 32'h0000_0011);
		send_request(KIND_SET, 32'h5555_aaaa, 32'h0000_0022);
		send_request(KIND_GET, 32'h0000_1234, $urandom);
		send_request(KIND_SET, 32'haaaa_5555, 32'h0000_0033);
		send_request(KIND_GET, 32'h5555_aaaa, $urandom);
		send_request(KIND_GET, 32'h0000_1234, $urandom);
		send_request(KIND_GET, 32'haaaa_5555, $urandom);
	endtask

	task automatic test_capacity_lowering();
		write_capacity(CAP_W'(4));
		send_request(KIND_SET, 32'h0f0f_0f0f, 32'h1111_1111);
		send_request(KIND_SET, 32'hf0f0_f0f0, 32'h2222_2222);
		write_capacity(CAP_W'(1));
		send_request(KIND_GET, 32'h0000_1234, $urandom);
		send_request(KIND_SET, 32'h0000_0001, 32'h3333_3333);
		send_request(KIND_GET, 32'h0f0f_0f0f, $urandom);
		send_request(KIND_GET, 32'h0000_0001, $urandom);
	endtask

	task automatic test_capacity_zero();
		write_capacity(CAP_W'(0));
		send_request(KIND_SET, 32'h0000_0002, 32'h4444_4444);
		send_request(KIND_SET, 32'h0000_0003, 32'h5555_5555);
		send_request(KIND_GET, 32'h0000_0002, $urandom);
		send_request(KIND_GET, 32'h0000_0003, $urandom);
		write_capacity(CAP_RESET);
	endtask

	task automatic test_random_traffic();
		int caps[12] = '{16, 1, 2, 31, 0, 4, 17, 8, 3, 16, 5, 12};
		logic [DATA_W-1:0] pool[$];
		int unsigned eff;
		int unsigned target;
		int unsigned pick;
		for (int p = 0; p < 12; p++) begin
			write_capacity(CAP_W'(caps[p]));
			sender_gapless = (p % 3 == 2);
			eff = (caps[p] == 0) ? 1 : (caps[p] > SLOTS) ? SLOTS : caps[p];
			pool.delete();
			if (p % 4 == 0) begin
				pool.push_back(KEY_MIN);
				pool.push_back(KEY_MAX);
				pool.push_back(32'd0);
				pool.push_back('1);
			end
			target = eff + $urandom_range(1, 4);
			while (pool.size() < target)
				pool.push_back($urandom);
			for (int n = 0; n < 150; n++) begin
				pick = $urandom_range(0, 99);
				if (pick < 8)
					send_request($urandom_range(0, 1) ? KIND_SET : KIND_GET, $urandom, $urandom);
				else
					send_request(pick < 55 ? KIND_GET : KIND_SET,
						pool[$urandom_range(0, pool.size() - 1)], $urandom);
			end
			// mid-run pause until every get is answered
			if (p == 5)
				settle();
		end
		sender_gapless = 1'b0;
	endtask

	task automatic test_backpressure();
		logic [DATA_W-1:0] hot[4];
		write_capacity(CAP_W'(8));
		sender_gapless = 1'b1;
		for (int i = 0; i < 4; i++) begin
			hot[i] = $urandom;
			send_request(KIND_SET, hot[i], $urandom);
		end
		hold_len = 400;
		hold_seq++;
		for (int n = 0; n < 40; n++)
			send_request($urandom_range(0, 4) == 0 ? KIND_SET : KIND_GET,
				hot[$urandom_range(0, 3)], $urandom);
		settle();
		sender_gapless = 1'b0;
	endtask

	initial begin
		arst_n <= 1'b0;
		req_ch.valid <= 1'b0;
		req_ch.kind <= KIND_GET;
		req_ch.key <= '0;
		req_ch.value <= '0;
		cfg_ch.valid <= 1'b0;
		cfg_ch.capacity <= CAP_RESET;
		shadow_live = 0;
		shadow_capacity = CAP_RESET;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_basic_lookups();
		test_eviction_order();
		test_capacity_lowering();
		test_capacity_zero();
		test_random_traffic();
		test_backpressure();
		settle();

		$display("covered %0d gets (%0d hits, %0d misses) and %0d sets", get_count,
			hit_count, miss_count, set_count);
		$display("over %0d capacity writes in %0d cycles, %0d mismatches", cap_writes,
			cycle_count, error_count);
		if (error_count == 0) begin
			$display("** lru_key_value_cache_unit: PASSED **");
		end else begin
			$display("** lru_key_value_cache_unit: FAILED **");
		end
		$finish;
	end

endmodule

### filelist.f
+incdir+design
design/lkv_pkg.sv
design/lkv_ifs.sv
design/lkv_cell.sv
design/lkv_ctrl.sv
design/lru_key_value_cache_unit.sv
design/lkv_checker.sv
test/tb_lru_key_value_cache_unit.sv
